>>> hw/rtl/llmc_pkg.sv
// Shared types, marker strings and helper functions for the log line marker capture unit.
`timescale 1ns / 1ps

package llmc_pkg;

    localparam int MARKERS = 4;
    localparam int PROG_W  = 6;

    localparam logic [32*8-1:0] MARK0 = "Start waypoint v3 mission failed";
    localparam logic [18*8-1:0] MARK1 = "waypoint v3 action";
    localparam logic [6*8-1:0]  MARK2 = "error:";
    localparam logic [6*8-1:0]  MARK3 = "failed";

    localparam logic [PROG_W-1:0] MARK_LEN [MARKERS] = '{6'd32, 6'd18, 6'd6, 6'd6};

    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NUL = 8'd0;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY
    } state_t;

    // Status of the line being assembled, as seen by the controller.
    typedef struct packed {
        logic nonempty;
        logic start_hit;
        logic action_hit;
    } scan_flags_t;

    // Character at position p of marker m; zero past the marker's end.
    function automatic logic [7:0] mark_char(input logic [1:0] m, input logic [4:0] p);
        int ip;
        logic [7:0] ch;
        ip = int'(p);
        ch = '0;
        case (m)
            2'd0: ch = MARK0[(31 - ip)*8 +: 8];
            2'd1: if (ip < 18) ch = MARK1[(17 - ip)*8 +: 8];
            2'd2: if (ip < 6) ch = MARK2[(5 - ip)*8 +: 8];
            2'd3: if (ip < 6) ch = MARK3[(5 - ip)*8 +: 8];
            default: ch = '0;
        endcase
        return ch;
    endfunction

    // None of the markers has a border, so a mismatch falls back to the first character.
    function automatic logic [PROG_W-1:0] mark_advance(input logic [1:0] m,
                                                       input logic [PROG_W-1:0] p,
                                                       input logic [7:0] c);
        logic [PROG_W-1:0] q;
        if (mark_char(m, p[4:0]) == c) begin
            q = p + 6'd1;
        end
        else if (mark_char(m, 5'd0) == c) begin
            q = 6'd1;
        end
        else begin
            q = '0;
        end
        return q;
    endfunction

endpackage

>>> hw/rtl/llmc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module llmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/llmc_scan.sv
// Line tracker: byte count, trim bounds, NUL detection and the four marker matchers.
`timescale 1ns / 1ps

module llmc_scan #(
    parameter int LINE_BYTES = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic                          clear,
    input  logic [7:0]                    data_byte,
    output logic                          wr_en,
    output logic [$clog2(LINE_BYTES)-1:0] count,
    output logic [$clog2(LINE_BYTES)-1:0] first_text,
    output logic [$clog2(LINE_BYTES)-1:0] last_text,
    output llmc_pkg::scan_flags_t         flags
);

    localparam int LW = $clog2(LINE_BYTES);

    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] first_reg, first_next;
    logic [LW-1:0] last_reg, last_next;
    logic          nul_reg, nul_next;
    logic [llmc_pkg::PROG_W-1:0] prog_reg [llmc_pkg::MARKERS];
    logic [llmc_pkg::PROG_W-1:0] prog_next [llmc_pkg::MARKERS];
    logic [llmc_pkg::MARKERS-1:0] found_reg, found_next;
    logic          room;
    logic          blank;
    logic          visible;

    assign room    = 32'(count_reg) < (LINE_BYTES - 1);
    assign blank   = (data_byte == llmc_pkg::CH_SP) || (data_byte == llmc_pkg::CH_TAB);
    assign visible = !(blank || data_byte == llmc_pkg::CH_CR || data_byte == llmc_pkg::CH_NL);
    assign wr_en   = take && room;

    always_comb
    begin
        count_next = count_reg;
        first_next = first_reg;
        last_next  = last_reg;
        nul_next   = nul_reg;
        found_next = found_reg;
        for (int m = 0; m < llmc_pkg::MARKERS; m++)
        begin
            prog_next[m] = prog_reg[m];
        end
        if (clear)
        begin
            count_next = '0;
            first_next = '0;
            last_next  = '0;
            nul_next   = 1'b0;
            found_next = '0;
            for (int m = 0; m < llmc_pkg::MARKERS; m++)
            begin
                prog_next[m] = '0;
            end
        end
        else if (wr_en)
        begin
            count_next = count_reg + LW'(1);
            if (!nul_reg)
            begin
                if (data_byte == llmc_pkg::CH_NUL)
                begin
                    nul_next = 1'b1;
                end
                else
                begin
                    if (first_reg == count_reg && blank)
                    begin
                        first_next = count_reg + LW'(1);
                    end
                    if (visible)
                    begin
                        last_next = count_reg + LW'(1);
                    end
                    for (int m = 0; m < llmc_pkg::MARKERS; m++)
                    begin
                        if (!found_reg[m])
                        begin
                            prog_next[m] = llmc_pkg::mark_advance(2'(m), prog_reg[m], data_byte);
                            found_next[m] = (prog_next[m] == llmc_pkg::MARK_LEN[m]);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            nul_reg   <= 1'b0;
            found_reg <= '0;
            for (int m = 0; m < llmc_pkg::MARKERS; m++)
            begin
                prog_reg[m] <= '0;
            end
        end
        else
        begin
            count_reg <= count_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            nul_reg   <= nul_next;
            found_reg <= found_next;
            for (int m = 0; m < llmc_pkg::MARKERS; m++)
            begin
                prog_reg[m] <= prog_next[m];
            end
        end
    end

    assign count      = count_reg;
    assign first_text = first_reg;
    assign last_text  = last_reg;
    assign flags.nonempty   = count_reg != '0;
    assign flags.start_hit  = found_reg[0];
    assign flags.action_hit = found_reg[1] && found_reg[2] && found_reg[3];

endmodule

>>> hw/rtl/log_line_marker_capture_unit.sv
// Top level of the log line marker capture unit: controller, copy engine and memories.
`timescale 1ns / 1ps

// A feed byte that is not a newline is handled in the cycle in which it is accepted. A
// read passes through the READ state, which waits for the registered read of the capture
// memory. A newline that closes a nonempty line copies at most KEEP_BYTES-1 bytes: the
// trimmed line is moved byte by byte through the single read port of the line memory
// into the capture memories of the markers that were hit, in one pass. The block takes
// no new item until the current one has placed its result in the output register; the
// memories need no clearing after reset.
module log_line_marker_capture_unit #(
    parameter int LINE_BYTES = 512,
    parameter int KEEP_BYTES = 320
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] data_byte,
    input  logic       store_select,
    input  logic [8:0] read_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       line_end,
    output logic       start_reject_hit,
    output logic       action_error_hit,
    output logic [7:0] read_byte,
    output logic       read_present,
    output logic [8:0] read_length
);

    localparam int LW = $clog2(LINE_BYTES);
    localparam int KW = $clog2(KEEP_BYTES);

    llmc_pkg::state_t state_reg, state_next;

    logic          out_valid_reg, out_valid_next;
    logic          line_end_reg, line_end_next;
    logic          hit0_out_reg, hit0_out_next;
    logic          hit1_out_reg, hit1_out_next;
    logic [7:0]    rbyte_reg, rbyte_next;
    logic          present_reg, present_next;
    logic [8:0]    rlen_reg, rlen_next;

    logic          sel_reg, sel_next;
    logic [8:0]    idx_reg, idx_next;
    logic          hit0_reg, hit0_next;
    logic          hit1_reg, hit1_next;
    logic [LW-1:0] beg_reg, beg_next;
    logic [KW-1:0] n_reg, n_next;
    logic [KW-1:0] rd_idx_reg, rd_idx_next;
    logic          wr_pend_reg, wr_pend_next;
    logic [KW-1:0] wr_idx_reg, wr_idx_next;
    logic [KW-1:0] cap_len_reg [2];
    logic [KW-1:0] cap_len_next [2];

    logic          out_free;
    logic          accept;
    logic          feed_take;
    logic          line_close;
    logic          copy_done;
    logic          issue;

    logic          scan_wr_en;
    logic [LW-1:0] scan_count;
    logic [LW-1:0] scan_first;
    logic [LW-1:0] scan_last;
    llmc_pkg::scan_flags_t scan_flags;

    logic [LW-1:0] beg_calc;
    logic [LW-1:0] span;
    logic [KW-1:0] n_calc;

    logic [LW-1:0] line_rd_addr;
    logic [7:0]    line_rd_data;
    logic [KW-1:0] cap_rd_addr;
    logic [7:0]    cap_rd_data [2];
    logic [KW-1:0] sel_len;
    logic [7:0]    sel_data;

    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == llmc_pkg::ST_IDLE) && out_free;
    assign accept     = in_valid && in_ready;
    assign feed_take  = accept && (cmd == llmc_pkg::CMD_FEED) && (data_byte != llmc_pkg::CH_NL);
    assign line_close = accept && (cmd == llmc_pkg::CMD_FEED) && (data_byte == llmc_pkg::CH_NL)
                        && scan_flags.nonempty;
    assign copy_done  = (rd_idx_reg == n_reg) && !wr_pend_reg;
    assign issue      = (state_reg == llmc_pkg::ST_COPY) && (rd_idx_reg != n_reg);

    llmc_scan #(
        .LINE_BYTES (LINE_BYTES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (feed_take),
        .clear      (line_close),
        .data_byte  (data_byte),
        .wr_en      (scan_wr_en),
        .count      (scan_count),
        .first_text (scan_first),
        .last_text  (scan_last),
        .flags      (scan_flags)
    );

    // Trimmed copy bounds; the copy is cut to KEEP_BYTES-1 bytes.
    assign beg_calc = (scan_first < scan_last) ? scan_first : scan_last;
    assign span     = scan_last - beg_calc;
    assign n_calc   = (32'(span) > (KEEP_BYTES - 1)) ? KW'(KEEP_BYTES - 1) : KW'(span);

    assign line_rd_addr = LW'(32'(beg_reg) + 32'(rd_idx_reg));
    assign cap_rd_addr  = (state_reg == llmc_pkg::ST_IDLE) ? KW'(read_index) : KW'(idx_reg);
    assign sel_len      = sel_reg ? cap_len_reg[1] : cap_len_reg[0];
    assign sel_data     = sel_reg ? cap_rd_data[1] : cap_rd_data[0];

    llmc_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (scan_wr_en),
        .wr_addr (scan_count),
        .wr_data (data_byte),
        .rd_addr (line_rd_addr),
        .rd_data (line_rd_data)
    );

    llmc_ram #(
        .WIDTH (8),
        .DEPTH (KEEP_BYTES)
    ) u_cap0_ram (
        .clk     (clk),
        .wr_en   (wr_pend_reg && hit0_reg),
        .wr_addr (wr_idx_reg),
        .wr_data (line_rd_data),
        .rd_addr (cap_rd_addr),
        .rd_data (cap_rd_data[0])
    );

    llmc_ram #(
        .WIDTH (8),
        .DEPTH (KEEP_BYTES)
    ) u_cap1_ram (
        .clk     (clk),
        .wr_en   (wr_pend_reg && hit1_reg),
        .wr_addr (wr_idx_reg),
        .wr_data (line_rd_data),
        .rd_addr (cap_rd_addr),
        .rd_data (cap_rd_data[1])
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            llmc_pkg::ST_IDLE:
            begin
                if (accept && cmd == llmc_pkg::CMD_READ)
                begin
                    state_next = llmc_pkg::ST_READ;
                end
                else if (line_close)
                begin
                    state_next = llmc_pkg::ST_COPY;
                end
            end
            llmc_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    state_next = llmc_pkg::ST_IDLE;
                end
            end
            llmc_pkg::ST_COPY:
            begin
                if (copy_done && out_free)
                begin
                    state_next = llmc_pkg::ST_IDLE;
                end
            end
            default: state_next = llmc_pkg::ST_IDLE;
        endcase
    end

    // Datapath and result register.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        line_end_next   = line_end_reg;
        hit0_out_next   = hit0_out_reg;
        hit1_out_next   = hit1_out_reg;
        rbyte_next      = rbyte_reg;
        present_next    = present_reg;
        rlen_next       = rlen_reg;
        sel_next        = sel_reg;
        idx_next        = idx_reg;
        hit0_next       = hit0_reg;
        hit1_next       = hit1_reg;
        beg_next        = beg_reg;
        n_next          = n_reg;
        rd_idx_next     = rd_idx_reg;
        wr_pend_next    = 1'b0;
        wr_idx_next     = wr_idx_reg;
        cap_len_next[0] = cap_len_reg[0];
        cap_len_next[1] = cap_len_reg[1];
        case (state_reg)
            llmc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == llmc_pkg::CMD_READ)
                    begin
                        sel_next = store_select;
                        idx_next = read_index;
                    end
                    else if (line_close)
                    begin
                        hit0_next   = scan_flags.start_hit;
                        hit1_next   = scan_flags.action_hit;
                        beg_next    = beg_calc;
                        n_next      = n_calc;
                        rd_idx_next = '0;
                        if (scan_flags.start_hit)
                        begin
                            cap_len_next[0] = n_calc;
                        end
                        if (scan_flags.action_hit)
                        begin
                            cap_len_next[1] = n_calc;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        line_end_next  = 1'b0;
                        hit0_out_next  = 1'b0;
                        hit1_out_next  = 1'b0;
                        rbyte_next     = '0;
                        present_next   = 1'b0;
                        rlen_next      = '0;
                    end
                end
            end
            llmc_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    line_end_next  = 1'b0;
                    hit0_out_next  = 1'b0;
                    hit1_out_next  = 1'b0;
                    rbyte_next     = (32'(idx_reg) < 32'(sel_len)) ? sel_data : 8'd0;
                    present_next   = sel_len != '0;
                    rlen_next      = 9'(sel_len);
                end
            end
            llmc_pkg::ST_COPY:
            begin
                // A byte read from the line memory is written to the capture memories in the following cycle.
                if (issue)
                begin
                    rd_idx_next  = rd_idx_reg + KW'(1);
                    wr_pend_next = 1'b1;
                    wr_idx_next  = rd_idx_reg;
                end
                if (copy_done && out_free)
                begin
                    out_valid_next = 1'b1;
                    line_end_next  = 1'b1;
                    hit0_out_next  = hit0_reg;
                    hit1_out_next  = hit1_reg;
                    rbyte_next     = '0;
                    present_next   = 1'b0;
                    rlen_next      = '0;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= llmc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            n_reg         <= '0;
            cap_len_reg[0] <= '0;
            cap_len_reg[1] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wr_pend_reg   <= wr_pend_next;
            rd_idx_reg    <= rd_idx_next;
            n_reg         <= n_next;
            cap_len_reg[0] <= cap_len_next[0];
            cap_len_reg[1] <= cap_len_next[1];
        end
    end

    always_ff @(posedge clk)
    begin
        line_end_reg <= line_end_next;
        hit0_out_reg <= hit0_out_next;
        hit1_out_reg <= hit1_out_next;
        rbyte_reg    <= rbyte_next;
        present_reg  <= present_next;
        rlen_reg     <= rlen_next;
        sel_reg      <= sel_next;
        idx_reg      <= idx_next;
        hit0_reg     <= hit0_next;
        hit1_reg     <= hit1_next;
        beg_reg      <= beg_next;
        wr_idx_reg   <= wr_idx_next;
    end

    assign out_valid        = out_valid_reg;
    assign line_end         = line_end_reg;
    assign start_reject_hit = hit0_out_reg;
    assign action_error_hit = hit1_out_reg;
    assign read_byte        = rbyte_reg;
    assign read_present     = present_reg;
    assign read_length      = rlen_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cap_len_reg[0]) < KEEP_BYTES) && (32'(cap_len_reg[1]) < KEEP_BYTES))
        else $error("capture length beyond store size");

    a_copy_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == llmc_pkg::ST_COPY) |-> (rd_idx_reg <= n_reg))
        else $error("copy read index ran past the copy length");

    a_wr_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg == llmc_pkg::ST_COPY))
        else $error("capture write outside of a copy");

    a_feed_result: assert property (@(posedge clk) disable iff (!rst_n)
        feed_take |=> (out_valid_reg && !line_end_reg && state_reg == llmc_pkg::ST_IDLE))
        else $error("plain feed item did not produce its result at once");

endmodule

>>> sim/log_line_marker_capture_checker.sv
// Checker for the log line marker capture unit: line and capture predictor plus result compare.
`timescale 1ns / 1ps

module log_line_marker_capture_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] data_byte,
    input  logic       store_select,
    input  logic [8:0] read_index,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       line_end,
    input  logic       start_reject_hit,
    input  logic       action_error_hit,
    input  logic [7:0] read_byte,
    input  logic       read_present,
    input  logic [8:0] read_length,
    output int         fail_count,
    output int         pending,
    output int         lines_closed,
    output int         start_captures,
    output int         action_captures
);

    localparam int LINE_MAX = 512;
    localparam int KEEP_MAX = 320;

    typedef struct {
        logic       line_end;
        logic       start_hit;
        logic       action_hit;
        logic [7:0] rd_byte;
        logic       rd_present;
        logic [8:0] rd_length;
    } line_result_t;

    line_result_t expected_results[$];

    logic [7:0] line_mem [LINE_MAX];
    int         line_len;
    bit         nul_hit;
    int         lead_ws;
    int         text_tail;
    int         progress [llmc_pkg::MARKERS];
    bit         found [llmc_pkg::MARKERS];
    logic [7:0] capture_mem [2][KEEP_MAX];
    int         capture_len [2];

    function automatic int marker_len(input int m);
        return int'(llmc_pkg::MARK_LEN[m]);
    endfunction

    function automatic logic [7:0] marker_byte(input int m, input int p);
        logic [7:0] ch;
        ch = '0;
        case (m)
            0: ch = llmc_pkg::MARK0[(31 - p)*8 +: 8];
            1: ch = llmc_pkg::MARK1[(17 - p)*8 +: 8];
            2: ch = llmc_pkg::MARK2[(5 - p)*8 +: 8];
            default: ch = llmc_pkg::MARK3[(5 - p)*8 +: 8];
        endcase
        return ch;
    endfunction

    // Longest marker prefix that is a suffix of the scanned text plus c.
    function automatic int next_progress(input int m, input int p, input logic [7:0] c);
        int  len;
        int  q;
        bit  ok;
        len = marker_len(m);
        if (p < len && marker_byte(m, p) == c)
            return p + 1;
        if (p >= len)
            p = len - 1;
        for (q = p; q > 0; q--) begin
            ok = (marker_byte(m, q - 1) == c);
            for (int i = 0; ok && i + 1 < q; i++)
                if (marker_byte(m, i) != marker_byte(m, p - q + 1 + i))
                    ok = 1'b0;
            if (ok)
                return q;
        end
        return 0;
    endfunction

    task automatic clear_line();
        line_len = 0;
        nul_hit = 1'b0;
        lead_ws = 0;
        text_tail = 0;
        for (int m = 0; m < llmc_pkg::MARKERS; m++)
        begin
            progress[m] = 0;
            found[m] = 1'b0;
        end
    endtask

    task automatic copy_line(input int which);
        int beg;
        int n;
        beg = (lead_ws < text_tail) ? lead_ws : text_tail;
        n = text_tail - beg;
        if (n > KEEP_MAX - 1)
            n = KEEP_MAX - 1;
        for (int i = 0; i < n; i++)
            capture_mem[which][i] = line_mem[beg + i];
        capture_len[which] = n;
    endtask

    task automatic store_byte(input logic [7:0] c);
        int pos;
        pos = line_len;
        if (pos >= LINE_MAX - 1)
            return;
        line_mem[pos] = c;
        line_len = pos + 1;
        if (nul_hit)
            return;
        if (c == llmc_pkg::CH_NUL)
        begin
            nul_hit = 1'b1;
            return;
        end
        if (lead_ws == pos && (c == llmc_pkg::CH_SP || c == llmc_pkg::CH_TAB))
            lead_ws = pos + 1;
        if (!(c == llmc_pkg::CH_CR || c == llmc_pkg::CH_NL || c == llmc_pkg::CH_SP
              || c == llmc_pkg::CH_TAB))
            text_tail = pos + 1;
        for (int m = 0; m < llmc_pkg::MARKERS; m++)
        begin
            if (!found[m])
            begin
                progress[m] = next_progress(m, progress[m], c);
                if (progress[m] >= marker_len(m))
                    found[m] = 1'b1;
            end
        end
    endtask

    task automatic predict_item(input logic c_cmd, input logic [7:0] c_byte,
                                input logic c_sel, input logic [8:0] c_idx);
        line_result_t r;
        int           len;
        r = '{1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 9'd0};
        if (c_cmd == llmc_pkg::CMD_READ)
        begin
            len = capture_len[c_sel];
            if (int'(c_idx) < len)
                r.rd_byte = capture_mem[c_sel][c_idx];
            r.rd_present = (len != 0);
            r.rd_length = len[8:0];
        end
        else if (c_byte != llmc_pkg::CH_NL)
            store_byte(c_byte);
        else if (line_len != 0)
        begin
            r.line_end = 1'b1;
            lines_closed++;
            if (found[0])
            begin
                copy_line(0);
                r.start_hit = 1'b1;
                start_captures++;
            end
            if (found[1] && found[2] && found[3])
            begin
                copy_line(1);
                r.action_hit = 1'b1;
                action_captures++;
            end
            clear_line();
        end
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        lines_closed = 0;
        start_captures = 0;
        action_captures = 0;
        capture_len[0] = 0;
        capture_len[1] = 0;
        clear_line();
    end

    assign pending = expected_results.size();

    always @(posedge clk)
    begin
        line_result_t e;
        if (rst_n)
        begin
            // A result leaving at this edge belongs to an earlier item, so compare first.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no item waiting", $time);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("line_end", int'(e.line_end), int'(line_end));
                    check_field("start_reject_hit", int'(e.start_hit), int'(start_reject_hit));
                    check_field("action_error_hit", int'(e.action_hit),
                                int'(action_error_hit));
                    check_field("read_byte", int'(e.rd_byte), int'(read_byte));
                    check_field("read_present", int'(e.rd_present), int'(read_present));
                    check_field("read_length", int'(e.rd_length), int'(read_length));
                end
            end
            if (in_valid && in_ready)
                predict_item(cmd, data_byte, store_select, read_index);
        end
    end

endmodule

>>> sim/tb_log_line_marker_capture_unit.sv
// Testbench top for the log line marker capture unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_log_line_marker_capture_unit;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       cmd;
    logic [7:0] data_byte;
    logic       store_select;
    logic [8:0] read_index;
    logic       out_valid;
    logic       out_ready;
    logic       line_end;
    logic       start_reject_hit;
    logic       action_error_hit;
    logic [7:0] read_byte;
    logic       read_present;
    logic [8:0] read_length;
    int         fail_count;
    int         pending;
    int         lines_closed;
    int         start_captures;
    int         action_captures;
    int         items_sent;

    log_line_marker_capture_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .data_byte(data_byte), .store_select(store_select),
        .read_index(read_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .line_end(line_end), .start_reject_hit(start_reject_hit),
        .action_error_hit(action_error_hit), .read_byte(read_byte),
        .read_present(read_present), .read_length(read_length)
    );

    log_line_marker_capture_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .data_byte(data_byte), .store_select(store_select),
        .read_index(read_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .line_end(line_end), .start_reject_hit(start_reject_hit),
        .action_error_hit(action_error_hit), .read_byte(read_byte),
        .read_present(read_present), .read_length(read_length),
        .fail_count(fail_count), .pending(pending), .lines_closed(lines_closed),
        .start_captures(start_captures), .action_captures(action_captures)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Receiver stalls: random runs of ready high or low, mostly short.
    initial
    begin
        int run;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = gap_length() + 1;
            out_ready <= ($urandom_range(0, 2) != 0);
            repeat (run) @(posedge clk);
        end
    end

    task automatic send_item(input logic c, input logic [7:0] b, input logic s,
                             input logic [8:0] idx);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        data_byte <= b;
        store_select <= s;
        read_index <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(llmc_pkg::CMD_FEED, s[i], 1'($urandom_range(0, 1)),
                      9'($urandom_range(0, 511)));
    endtask

    task automatic read_store(input logic s, input logic [8:0] idx);
        send_item(llmc_pkg::CMD_READ, 8'($urandom_range(0, 255)), s, idx);
    endtask

    task automatic random_reads();
        int n;
        int r;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                read_store(1'($urandom_range(0, 1)), 9'($urandom_range(0, 40)));
            else if (r < 5)
                read_store(1'($urandom_range(0, 1)), 9'($urandom_range(316, 319)));
            else
                read_store(1'($urandom_range(0, 1)), 9'($urandom_range(0, 319)));
        end
    endtask

    function automatic string filler(input int n);
        string s;
        int    r;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
                s = {s, " "};
            else if (r == 2)
                s = {s, "\t"};
            else
                s = {s, string'(8'($urandom_range(33, 126)))};
        end
        return s;
    endfunction

    function automatic string lead_ws();
        string s;
        s = "";
        repeat ($urandom_range(0, 3))
        begin
            if ($urandom_range(0, 1) != 0)
                s = {s, " "};
            else
                s = {s, "\t"};
        end
        return s;
    endfunction

    function automatic string tail_ws();
        string s;
        int    r;
        s = "";
        repeat ($urandom_range(0, 3))
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
                s = {s, " "};
            else if (r == 1)
                s = {s, "\t"};
            else
                s = {s, "\r"};
        end
        return s;
    endfunction

    function automatic string action_body();
        string parts [3];
        string t;
        int    j;
        parts[0] = "waypoint v3 action";
        parts[1] = "error:";
        parts[2] = "failed";
        for (int i = 2; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = parts[i];
            parts[i] = parts[j];
            parts[j] = t;
        end
        return {parts[0], filler($urandom_range(0, 8)), parts[1],
                filler($urandom_range(0, 8)), parts[2]};
    endfunction

    task automatic random_line();
        int    kind;
        string s;
        kind = $urandom_range(0, 99);
        if (kind < 25)
            s = {lead_ws(), filler($urandom_range(0, 10)), "Start waypoint v3 mission failed",
                 filler($urandom_range(0, 10)), tail_ws()};
        else if (kind < 50)
            s = {lead_ws(), filler($urandom_range(0, 6)), action_body(),
                 filler($urandom_range(0, 6)), tail_ws()};
        else if (kind < 60)
            s = {lead_ws(), "Start waypoint v3 mission failed ", action_body(), tail_ws()};
        else if (kind < 72)
            // Near misses: partial markers and repeated prefixes.
            s = {lead_ws(), "Start waypoint v3 mission faile", filler(2), "waypoint v3 actio",
                 " error failed errror: ffailed", tail_ws()};
        else if (kind < 96)
        begin
            s = "";
            repeat ($urandom_range(1, 20))
            begin
                if ($urandom_range(0, 3) == 0)
                    s = {s, string'(8'($urandom_range(0, 9)))};
                else
                    s = {s, string'(8'($urandom_range(11, 255)))};
            end
            feed_text(s);
            if ($urandom_range(0, 4) == 0)
                send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NUL, 1'b0, 9'd0);
            feed_text({filler(3), "failed"});
            s = "";
        end
        else
            s = {lead_ws(), "Start waypoint v3 mission failed ", action_body(),
                 filler($urandom_range(250, 540)), tail_ws()};
        feed_text(s);
        send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NL, 1'($urandom_range(0, 1)),
                  9'($urandom_range(0, 511)));
        random_reads();
    endtask

    initial
    begin
        int wait_cycles;
        items_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = llmc_pkg::CMD_FEED;
        data_byte = 8'd0;
        store_select = 1'b0;
        read_index = 9'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty stores, then an empty line that must not close anything.
        read_store(1'b0, 9'd0);
        read_store(1'b1, 9'd319);
        send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NL, 1'b0, 9'd0);
        // Trimmed start reject capture, and the action error capture with markers spread out.
        feed_text(" \t Start waypoint v3 mission failed \t\r\r ");
        send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NL, 1'b0, 9'd0);
        read_store(1'b0, 9'd0);
        read_store(1'b0, 9'd31);
        read_store(1'b0, 9'd32);
        feed_text("\tx failed, waypoint v3 action error: code\r");
        send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NL, 1'b1, 9'd0);
        read_store(1'b1, 9'd0);
        read_store(1'b1, 9'd319);
        // A line of a single NUL closes but captures nothing; text after a NUL is hidden.
        send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NUL, 1'b0, 9'd0);
        send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NL, 1'b0, 9'd0);
        feed_text("ab");
        send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NUL, 1'b0, 9'd0);
        feed_text("Start waypoint v3 mission failed");
        send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NL, 1'b0, 9'd0);
        send_item(llmc_pkg::CMD_FEED, 8'hFF, 1'b0, 9'd0);
        send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NL, 1'b0, 9'd0);
        // Overlong line with a capture cut to 319 bytes, and a marker past the line end.
        feed_text({"Start waypoint v3 mission failed", filler(600)});
        send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NL, 1'b0, 9'd0);
        read_store(1'b0, 9'd318);
        read_store(1'b0, 9'd319);
        feed_text({filler(520), "waypoint v3 action error: failed"});
        send_item(llmc_pkg::CMD_FEED, llmc_pkg::CH_NL, 1'b0, 9'd0);
        read_store(1'b1, 9'd5);

        while (items_sent < 1650)
            random_line();
        read_store(1'b0, 9'd0);
        read_store(1'b1, 9'd0);

        in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (400) @(posedge clk);
        $display("Sent %0d items; %0d lines closed, %0d start reject and %0d action error captures.",
                 items_sent, lines_closed, start_captures, action_captures);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/llmc_pkg.sv
hw/rtl/llmc_ram.sv
hw/rtl/llmc_scan.sv
hw/rtl/log_line_marker_capture_unit.sv
sim/log_line_marker_capture_checker.sv
sim/tb_log_line_marker_capture_unit.sv
